// ===== rtl/bfpw_pkg.sv =====
// Shared types and constants for the blocking FIFO with priority wakeup.
package bfpw_pkg;
    localparam int DEPTH_DEF       = 16;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int WAIT_DEPTH_DEF  = 8;
    localparam int PRIO_LEVELS_DEF = 16;
    localparam int ID_W            = 8;
    localparam int PRIO_W          = 4;
    localparam int CFG_W           = 5;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Command from the control to one wait-list chain.
    typedef struct packed {
        logic             file_en;
        logic             wake_en;
        logic [ID_W-1:0]  id;
        logic [PRIO_W-1:0] prio;
    } t_wl_cmd;
endpackage

// ===== rtl/bfpw_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface bfpw_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [bfpw_pkg::ID_W-1:0]     task_id;
    logic [bfpw_pkg::PRIO_W-1:0]   task_priority;
    logic [31:0]                   push_data;
    modport source (output valid, op, task_id, task_priority, push_data, input ready);
    modport sink   (input valid, op, task_id, task_priority, push_data, output ready);
endinterface

interface bfpw_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [31:0]               read_data;
    logic                      woken_valid;
    logic [bfpw_pkg::ID_W-1:0] woken_task;
    modport source (output valid, status, read_data, woken_valid, woken_task, input ready);
    modport sink   (input valid, status, read_data, woken_valid, woken_task, output ready);
endinterface

// ===== rtl/bfpw_cell.sv =====
// One wait-list slot: holds a waiter and passes the running best to its neighbor.
module bfpw_cell #(
    parameter int IDX_W = 3
) (
    input  logic                        i_clk,
    input  logic [IDX_W:0]              i_pos,
    input  logic [IDX_W:0]              i_count,
    input  bfpw_pkg::t_wl_cmd           i_cmd,
    input  logic [IDX_W:0]              i_rm_pos,
    input  logic [bfpw_pkg::ID_W-1:0]   i_nxt_id,
    input  logic [bfpw_pkg::PRIO_W-1:0] i_nxt_prio,
    input  logic                        i_best_vld,
    input  logic [bfpw_pkg::PRIO_W-1:0] i_best_prio,
    input  logic [IDX_W:0]              i_best_pos,
    output logic [bfpw_pkg::ID_W-1:0]   o_id,
    output logic [bfpw_pkg::PRIO_W-1:0] o_prio,
    output logic                        o_best_vld,
    output logic [bfpw_pkg::PRIO_W-1:0] o_best_prio,
    output logic [IDX_W:0]              o_best_pos
);
    logic [bfpw_pkg::ID_W-1:0]   r_id;
    logic [bfpw_pkg::PRIO_W-1:0] r_prio;
    logic                        occ;

    assign occ    = i_pos < i_count;
    assign o_id   = r_id;
    assign o_prio = r_prio;

    // Strict less-than keeps the earliest waiter on a tie.
    always_comb begin
        o_best_vld  = i_best_vld;
        o_best_prio = i_best_prio;
        o_best_pos  = i_best_pos;
        if (occ && (!i_best_vld || r_prio < i_best_prio)) begin
            o_best_vld  = 1'b1;
            o_best_prio = r_prio;
            o_best_pos  = i_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.file_en && i_pos == i_count) begin
            r_id   <= i_cmd.id;
            r_prio <= i_cmd.prio;
        end else if (i_cmd.wake_en && i_pos >= i_rm_pos) begin
            r_id   <= i_nxt_id;
            r_prio <= i_nxt_prio;
        end
    end
endmodule

// ===== rtl/bfpw_wlist.sv =====
// Wait list built as a chain of cells with a registered best-waiter result.
module bfpw_wlist #(
    parameter int WAIT_DEPTH = bfpw_pkg::WAIT_DEPTH_DEF,
    parameter int IDX_W      = $clog2(WAIT_DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bfpw_pkg::t_wl_cmd         i_cmd,
    output logic [IDX_W:0]            o_count,
    output logic                      o_best_vld,
    output logic [bfpw_pkg::ID_W-1:0] o_best_id
);
    localparam int PW = bfpw_pkg::PRIO_W;
    logic [IDX_W:0] r_count, r_best_pos;
    logic           r_best_vld;
    logic [bfpw_pkg::ID_W-1:0] id_a [WAIT_DEPTH+1];
    logic [PW-1:0]             pr_a [WAIT_DEPTH+1];
    logic                      bv [WAIT_DEPTH+1];
    logic [PW-1:0]             bp [WAIT_DEPTH+1];
    logic [IDX_W:0]            bpos [WAIT_DEPTH+1];
    logic [bfpw_pkg::ID_W-1:0] best_id;

    assign id_a[WAIT_DEPTH] = '0;
    assign pr_a[WAIT_DEPTH] = '0;
    assign bv[0]   = 1'b0;
    assign bp[0]   = '0;
    assign bpos[0] = '0;

    for (genvar g = 0; g < WAIT_DEPTH; g++) begin : g_cell
        bfpw_cell #(.IDX_W(IDX_W)) u_cell (
            .i_clk,
            .i_pos((IDX_W+1)'(g)), .i_count(r_count), .i_cmd,
            .i_rm_pos(r_best_pos),
            .i_nxt_id(id_a[g+1]), .i_nxt_prio(pr_a[g+1]),
            .i_best_vld(bv[g]), .i_best_prio(bp[g]), .i_best_pos(bpos[g]),
            .o_id(id_a[g]), .o_prio(pr_a[g]),
            .o_best_vld(bv[g+1]), .o_best_prio(bp[g+1]), .o_best_pos(bpos[g+1])
        );
    end

    // Best waiter is registered each cycle; control uses it in the cycle after a request is accepted.
    always_comb begin
        best_id = '0;
        for (int k = 0; k < WAIT_DEPTH; k++)
            if (r_best_pos == (IDX_W+1)'(k)) best_id = id_a[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_best_vld <= 1'b0;
            r_best_pos <= '0;
        end else begin
            r_best_vld <= bv[WAIT_DEPTH];
            r_best_pos <= bpos[WAIT_DEPTH];
            if (i_cmd.file_en) r_count <= r_count + 1'b1;
            else if (i_cmd.wake_en) r_count <= r_count - 1'b1;
        end
    end

    assign o_count    = r_count;
    assign o_best_vld = r_best_vld;
    assign o_best_id  = best_id;
endmodule

// ===== rtl/blocking_fifo_priority_wake.sv =====
// Top level: word FIFO with sender and receiver priority wait lists.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | op, task_id, task_priority, push_data
//  rsp     | out | valid/ready   | status, read_data, woken_valid, woken_task
//  cfg     | in  | i_cfg_we      | i_cfg_wdata (queue_length)
//
// A request is accepted in S_IDLE, which lets the best-waiter scan through the
// cell chains settle into a register; S_EXEC then updates state and loads the
// result register. A new request is taken only while the result
// register is empty or being drained. Reset is synchronous and clears all
// control state; the slot store and wait-list cells need no reset.
module blocking_fifo_priority_wake #(
    parameter int DEPTH       = bfpw_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH  = bfpw_pkg::DATA_WIDTH_DEF,
    parameter int WAIT_DEPTH  = bfpw_pkg::WAIT_DEPTH_DEF,
    parameter int PRIO_LEVELS = bfpw_pkg::PRIO_LEVELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bfpw_pkg::CFG_W-1:0] i_cfg_wdata,
    bfpw_req_if.sink                   i_req,
    bfpw_rsp_if.source                 o_rsp
);
    localparam int AW    = $clog2(DEPTH);
    localparam int IDX_W = $clog2(WAIT_DEPTH);
    localparam int PW    = bfpw_pkg::PRIO_W;
    localparam int IW    = bfpw_pkg::ID_W;

    typedef enum logic {S_IDLE, S_EXEC} t_state;
    t_state r_state;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]  r_rd_idx, r_wr_idx;
    logic [AW:0]    r_fill, r_qlen;
    logic           r_op;
    logic [IW-1:0]  r_id;
    logic [PW-1:0]  r_prio;
    logic [DATA_WIDTH-1:0] r_wdata;
    logic           r_ovld;
    logic [1:0]     r_status;
    logic [31:0]    r_rdata;
    logic           r_wv;
    logic [IW-1:0]  r_wt;

    bfpw_pkg::t_wl_cmd snd_cmd, rcv_cmd;
    logic [IDX_W:0] snd_cnt, rcv_cnt;
    logic           snd_bv, rcv_bv;
    logic [IW-1:0]  snd_bid, rcv_bid;
    logic           req_go, is_full, is_empty, tgt_full;
    logic [PW-1:0]  fprio;
    logic [AW:0]    cfg_len;

    assign i_req.ready = (r_state == S_IDLE) && (!r_ovld || o_rsp.ready);
    assign req_go   = i_req.valid && i_req.ready;
    assign is_full  = r_fill >= r_qlen;
    assign is_empty = r_fill == '0;
    assign tgt_full = (r_op == bfpw_pkg::OP_SEND)
                    ? (snd_cnt >= (IDX_W+1)'(WAIT_DEPTH))
                    : (rcv_cnt >= (IDX_W+1)'(WAIT_DEPTH));
    assign fprio = (int'(r_prio) >= PRIO_LEVELS) ? PW'(PRIO_LEVELS - 1) : r_prio;

    always_comb begin
        snd_cmd = '{file_en: 1'b0, wake_en: 1'b0, id: r_id, prio: fprio};
        rcv_cmd = snd_cmd;
        if (r_state == S_EXEC) begin
            if (r_op == bfpw_pkg::OP_SEND) begin
                snd_cmd.file_en = is_full && !tgt_full;
                rcv_cmd.wake_en = !is_full && rcv_bv;
            end else begin
                rcv_cmd.file_en = is_empty && !tgt_full;
                snd_cmd.wake_en = !is_empty && snd_bv;
            end
        end
    end

    bfpw_wlist #(.WAIT_DEPTH(WAIT_DEPTH), .IDX_W(IDX_W)) u_snd (
        .i_clk, .i_rst_n, .i_cmd(snd_cmd),
        .o_count(snd_cnt), .o_best_vld(snd_bv), .o_best_id(snd_bid));
    bfpw_wlist #(.WAIT_DEPTH(WAIT_DEPTH), .IDX_W(IDX_W)) u_rcv (
        .i_clk, .i_rst_n, .i_cmd(rcv_cmd),
        .o_count(rcv_cnt), .o_best_vld(rcv_bv), .o_best_id(rcv_bid));

    always_comb begin
        if (i_cfg_wdata == '0) cfg_len = (AW+1)'(1);
        else if (32'(i_cfg_wdata) > 32'(DEPTH)) cfg_len = (AW+1)'(DEPTH);
        else cfg_len = (AW+1)'(i_cfg_wdata);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && r_op == bfpw_pkg::OP_SEND && !is_full)
            r_mem[r_wr_idx] <= r_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_fill   <= '0;
            r_qlen   <= (AW+1)'(DEPTH);
            r_ovld   <= 1'b0;
        end else begin
            if (r_state == S_EXEC) r_ovld <= 1'b1;
            else if (o_rsp.ready) r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    // Length writes need no call in flight; user-enforced.
                    if (i_cfg_we && is_empty) begin
                        r_qlen   <= cfg_len;
                        r_rd_idx <= '0;
                        r_wr_idx <= '0;
                    end
                    if (req_go) begin
                        r_op    <= i_req.op;
                        r_id    <= i_req.task_id;
                        r_prio  <= i_req.task_priority;
                        r_wdata <= DATA_WIDTH'(i_req.push_data);
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state  <= S_IDLE;
                    r_status <= bfpw_pkg::ST_DONE;
                    r_rdata  <= '0;
                    r_wv     <= 1'b0;
                    r_wt     <= '0;
                    if (r_op == bfpw_pkg::OP_SEND) begin
                        if (is_full) begin
                            r_status <= tgt_full ? bfpw_pkg::ST_FULL : bfpw_pkg::ST_BLOCKED;
                        end else begin
                            r_wr_idx <= (32'(r_wr_idx) + 1 >= 32'(r_qlen)) ? '0
                                                                         : r_wr_idx + 1'b1;
                            r_fill   <= r_fill + 1'b1;
                            r_wv     <= rcv_bv;
                            r_wt     <= rcv_bv ? rcv_bid : '0;
                        end
                    end else begin
                        if (is_empty) begin
                            r_status <= tgt_full ? bfpw_pkg::ST_FULL : bfpw_pkg::ST_BLOCKED;
                        end else begin
                            r_rdata  <= 32'(r_mem[r_rd_idx]);
                            r_rd_idx <= (32'(r_rd_idx) + 1 >= 32'(r_qlen)) ? '0
                                                                         : r_rd_idx + 1'b1;
                            r_fill   <= r_fill - 1'b1;
                            r_wv     <= snd_bv;
                            r_wt     <= snd_bv ? snd_bid : '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid       = r_ovld;
    assign o_rsp.status      = r_status;
    assign o_rsp.read_data   = r_rdata;
    assign o_rsp.woken_valid = r_wv;
    assign o_rsp.woken_task  = r_wt;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_qlen) else $error("fill exceeds queue length");
    a_no_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |-> !i_req.ready) else $error("accept while executing");
    a_result_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> r_ovld) else $error("result not loaded");
    a_woken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !r_wv |-> r_wt == '0) else $error("woken task without wake");
endmodule

// ===== test/bfpw_checker.sv =====
// Checker for the blocking FIFO: predicts each call result and compares the responses.
`timescale 1ns / 100ps
module bfpw_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bfpw_pkg::CFG_W-1:0] i_cfg_wdata,
    bfpw_req_if                        i_req,
    bfpw_rsp_if                        i_rsp,
    output int                         o_fail_count,
    output int                         o_pending,
    output logic [4:0]                 o_fill
);
    localparam int SLOTS      = 16;
    localparam int WAIT_SLOTS = 8;
    localparam int SND_LIST   = 0;
    localparam int RCV_LIST   = 1;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] read_data;
        logic        woken_valid;
        logic [7:0]  woken_task;
    } t_call_result;

    t_call_result expected_results[$];

    logic [31:0] slot_word [SLOTS];
    logic [3:0]  rd_ptr;
    logic [3:0]  wr_ptr;
    logic [4:0]  fill;
    logic [4:0]  qlen;
    logic [7:0]  wl_id   [2][WAIT_SLOTS];
    logic [3:0]  wl_prio [2][WAIT_SLOTS];
    int          wl_cnt  [2];

    assign o_pending = expected_results.size();
    assign o_fill    = fill;

    function automatic logic [3:0] next_ptr(input logic [3:0] p);
        return (p + 5'd1 >= qlen) ? 4'd0 : p + 4'd1;
    endfunction

    task automatic file_caller(input int l, input logic [7:0] id, input logic [3:0] prio,
                               output logic [1:0] status);
        if (wl_cnt[l] >= WAIT_SLOTS) begin
            status = bfpw_pkg::ST_FULL;
        end else begin
            wl_id[l][wl_cnt[l]]   = id;
            wl_prio[l][wl_cnt[l]] = prio;
            wl_cnt[l]++;
            status = bfpw_pkg::ST_BLOCKED;
        end
    endtask

    // The first waiter with the lowest priority number is released; the rest close up.
    task automatic release_most_urgent(input int l, output logic v, output logic [7:0] id);
        int best;
        best = 0;
        v = 1'b0;
        id = '0;
        if (wl_cnt[l] != 0) begin
            for (int i = 1; i < wl_cnt[l]; i++)
                if (wl_prio[l][i] < wl_prio[l][best]) best = i;
            id = wl_id[l][best];
            v = 1'b1;
            for (int i = best; i + 1 < wl_cnt[l]; i++) begin
                wl_id[l][i]   = wl_id[l][i+1];
                wl_prio[l][i] = wl_prio[l][i+1];
            end
            wl_cnt[l]--;
        end
    endtask

    task automatic predict_call(output t_call_result r);
        r = '{bfpw_pkg::ST_DONE, 32'd0, 1'b0, 8'd0};
        if (i_req.op == bfpw_pkg::OP_SEND) begin
            if (fill >= qlen) begin
                file_caller(SND_LIST, i_req.task_id, i_req.task_priority, r.status);
            end else begin
                slot_word[wr_ptr] = i_req.push_data;
                wr_ptr = next_ptr(wr_ptr);
                fill++;
                release_most_urgent(RCV_LIST, r.woken_valid, r.woken_task);
            end
        end else begin
            if (fill == 0) begin
                file_caller(RCV_LIST, i_req.task_id, i_req.task_priority, r.status);
            end else begin
                r.read_data = slot_word[rd_ptr];
                rd_ptr = next_ptr(rd_ptr);
                fill--;
                release_most_urgent(SND_LIST, r.woken_valid, r.woken_task);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_call_result exp_r;
        logic [4:0]   v;
        if (!i_rst_n) begin
            rd_ptr = '0;
            wr_ptr = '0;
            fill = '0;
            qlen = 5'd16;
            wl_cnt[SND_LIST] = 0;
            wl_cnt[RCV_LIST] = 0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    $error("response transfer with no call outstanding");
                    o_fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_rsp.status !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status, i_rsp.status);
                        o_fail_count++;
                    end
                    if (i_rsp.read_data !== exp_r.read_data) begin
                        $error("read_data: expected %h, actual %h",
                               exp_r.read_data, i_rsp.read_data);
                        o_fail_count++;
                    end
                    if (i_rsp.woken_valid !== exp_r.woken_valid) begin
                        $error("woken_valid: expected %0d, actual %0d",
                               exp_r.woken_valid, i_rsp.woken_valid);
                        o_fail_count++;
                    end
                    if (i_rsp.woken_task !== exp_r.woken_task) begin
                        $error("woken_task: expected %0d, actual %0d",
                               exp_r.woken_task, i_rsp.woken_task);
                        o_fail_count++;
                    end
                end
            end
            // A length change only takes effect on an empty queue.
            if (i_cfg_we && fill == 0) begin
                v = i_cfg_wdata;
                if (v < 5'd1) v = 5'd1;
                if (v > 5'(SLOTS)) v = 5'(SLOTS);
                qlen = v;
                rd_ptr = '0;
                wr_ptr = '0;
            end
            if (i_req.valid && i_req.ready) begin
                predict_call(exp_r);
                expected_results.push_back(exp_r);
            end
        end
    end
endmodule

// ===== test/tb.sv =====
// Top of the testbench: clock, reset, call stimulus, configuration and verdict.
`timescale 1ns / 100ps
module tb;
    logic                       i_clk;
    logic                       i_rst_n;
    logic                       cfg_we;
    logic [bfpw_pkg::CFG_W-1:0] cfg_wdata;
    int                         fail_count;
    int                         pending;
    logic [4:0]                 fill;
    int                         snd_idle;
    int                         rcv_idle;
    int                         cycle_cnt;

    bfpw_req_if req_ch ();
    bfpw_rsp_if rsp_ch ();

    blocking_fifo_priority_wake u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    bfpw_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_fill       (fill)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 300000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk)
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);

    // One call; the valid stays high across back-to-back transfers.
    task automatic call(input logic op, input logic [7:0] id, input logic [3:0] prio,
                        input logic [31:0] data);
        if ($urandom_range(99) < snd_idle) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.op            <= op;
        req_ch.task_id       <= id;
        req_ch.task_priority <= prio;
        req_ch.push_data     <= data;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic write_length(input logic [bfpw_pkg::CFG_W-1:0] v, input bit drain);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        if (drain) begin
            while (fill != 0) begin
                call(bfpw_pkg::OP_RECV, 8'($urandom), 4'($urandom), $urandom);
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
        repeat (4) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_calls(input int n);
        int send_pct;
        send_pct = 50;
        for (int i = 0; i < n; i++) begin
            // Bias shifts now and then so the queue swings between empty and full.
            if (i % 20 == 0) send_pct = 20 + 30 * $urandom_range(2);
            call(($urandom_range(99) < send_pct) ? bfpw_pkg::OP_SEND : bfpw_pkg::OP_RECV,
                 8'($urandom), 4'($urandom), $urandom);
        end
    endtask

    initial begin
        cycle_cnt = 0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.op = bfpw_pkg::OP_SEND;
        req_ch.task_id = '0;
        req_ch.task_priority = '0;
        req_ch.push_data = '0;
        rsp_ch.ready = 1'b0;
        snd_idle = 14;
        rcv_idle = 86;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short queue, blocked receivers, full sender list, priority ties.
        write_length(5'd2, 1'b0);
        call(bfpw_pkg::OP_RECV, 8'd0, 4'd5, 32'd0);
        call(bfpw_pkg::OP_RECV, 8'd255, 4'd5, 32'd0);
        call(bfpw_pkg::OP_SEND, 8'd1, 4'd0, 32'hFFFF_FFFF);
        call(bfpw_pkg::OP_SEND, 8'd2, 4'd15, 32'h0000_0000);
        call(bfpw_pkg::OP_SEND, 8'd3, 4'd0, 32'hA5A5_5A5A);
        call(bfpw_pkg::OP_SEND, 8'd4, 4'd0, 32'h1234_5678);
        for (int i = 0; i < 9; i++)
            call(bfpw_pkg::OP_SEND, 8'(10 + i), (i == 3 || i == 6) ? 4'd1 : 4'd15, i);
        write_length(5'd9, 1'b0);
        for (int i = 0; i < 4; i++) call(bfpw_pkg::OP_RECV, 8'(200 + i), 4'd15, 32'd0);
        write_length(5'd0, 1'b1);
        call(bfpw_pkg::OP_SEND, 8'd20, 4'd7, 32'h8000_0001);
        call(bfpw_pkg::OP_SEND, 8'd21, 4'd7, 32'h7FFF_FFFE);
        call(bfpw_pkg::OP_RECV, 8'd22, 4'd7, 32'd0);
        write_length(5'd31, 1'b1);
        random_calls(135);

        snd_idle = 86;
        rcv_idle = 14;
        write_length(5'd1, 1'b1);
        random_calls(130);

        snd_idle = 0;
        rcv_idle = 0;
        write_length(5'($urandom_range(2, 15)), 1'b1);
        random_calls(135);

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/bfpw_pkg.sv
rtl/bfpw_if.sv
rtl/bfpw_cell.sv
rtl/bfpw_wlist.sv
rtl/blocking_fifo_priority_wake.sv
test/bfpw_checker.sv
test/tb.sv
